### rtl/ini_text_line_parser_macros.svh
// ----------------------------------------------------------------------------
// INI line parser assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef INI_TEXT_LINE_PARSER_MACROS_SVH
`define INI_TEXT_LINE_PARSER_MACROS_SVH

// same-cycle implication
`define ILP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ilp: same-cycle check failed");

// next-cycle implication
`define ILP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ilp: next-cycle check failed");

`endif

### rtl/ilp_pkg.sv
// ----------------------------------------------------------------------------
// INI line parser package
// Shared constants, codes, command and status types.
// ----------------------------------------------------------------------------
package ilp_pkg;

   localparam int LINE_BYTES_DEF    = 64;
   localparam int SECTION_BYTES_DEF = 50;
   localparam int CSR_ADDR_W        = 2;
   localparam int RSP_DATA_W        = 48;
   localparam int RSP_PAD_W         = 5;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_LBR   = 8'h5B;
   localparam logic [7:0] CH_RBR   = 8'h5D;
   localparam logic [7:0] BOM_0    = 8'hEF;
   localparam logic [7:0] BOM_1    = 8'hBB;
   localparam logic [7:0] BOM_2    = 8'hBF;

   typedef enum logic [1:0] {
      ROLE_SECTION, ROLE_NAME, ROLE_VALUE, ROLE_STATUS
   } role_type;

   typedef enum logic [2:0] {
      KIND_BLANK, KIND_SECTION, KIND_PAIR, KIND_CONT, KIND_ERROR,
      KIND_IGNORED, KIND_FILE_END
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ALLOW_BOM, CSR_ALLOW_MULTILINE, CSR_STOP_ON_ERROR
   } csr_type;

   typedef enum logic [1:0] {
      PLAN_EMPTY, PLAN_CONT, PLAN_SECT, PLAN_PAIR
   } plan_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLASS, ST_SCAN, ST_DECIDE, ST_VSCAN, ST_EMIT_CHK,
      ST_READ, ST_EMIT, ST_STATUS, ST_FILE_END
   } state_type;

   typedef struct packed {
      logic     wr_byte;
      logic     line_begin;
      logic     load_scan;
      logic     load_vscan;
      logic     scan_run;
      logic     set_plan;
      plan_type plan;
      kind_type kind;
      logic     next_span;
      logic     rd_issue;
      logic     out_load;
      logic     out_status;
      logic     out_file_end;
      logic     out_last;
      logic     line_done;
      logic     parser_reset;
   } cmd_type;

   typedef struct packed {
      logic ends_line;
      logic has_line;
      logic stopped;
      logic blank;
      logic cont;
      logic is_sect;
      logic scan_done;
      logic sect_ok;
      logic pair_found;
      logic cur_valid;
      logic span_b;
      logic out_free;
   } status_type;

   // C-locale whitespace: space and 9..13
   function automatic logic is_ws(input logic [7:0] c);
      return c inside {CH_SPACE, [CH_TAB:CH_CR]};
   endfunction

endpackage

### rtl/ini_text_line_parser.sv
// ----------------------------------------------------------------------------
// INI text line parser
// Byte stream in, classified line content and one status item per line out.
// ----------------------------------------------------------------------------
//
//  channel | dir | fields (low bit first)
//  --------+-----+-----------------------------------------------------------
//  req_    | in  | tdata: text_byte[7:0]; tuser: end_of_text
//  rsp_    | out | tdata: out_byte, line_kind, line_number, first_error_line;
//          |     | tuser: role; tlast: final item of the input item
//  csr_    | in  | we, addr (0 allow_bom, 1 allow_multiline, 2 stop_on_error)
//
// Text bytes are taken only while the block is idle; bytes are not re-read
// until the line ends. At line end the line is classified; if needed, a
// delimiter scan runs from the first to the last kept character, then a
// decide step; a pair's value scan reads the bytes after the delimiter. Each
// byte item takes a cursor check, store read and load; the status item and, at
// end of text, the file end status follow. Synchronous active-high reset.
// A stalled result holds the block in its output step until rsp_tready returns.
//
`include "ini_text_line_parser_macros.svh"

module ini_text_line_parser #(
   parameter int LINE_BYTES    = ilp_pkg::LINE_BYTES_DEF,
   parameter int SECTION_BYTES = ilp_pkg::SECTION_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // text_byte
   input  logic                           req_tuser,   // end_of_text
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_byte[7:0], line_kind[10:8], line_number[26:11], first_error_line[42:27]
   output logic [ilp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                     rsp_tuser,   // role
   output logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [ilp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic                           csr_wdata
);
   import ilp_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: intake, scans, emission order
   ilp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_eot    (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // line store, trackers and output register
   ilp_datapath #(
      .LINE_BYTES    (LINE_BYTES),
      .SECTION_BYTES (SECTION_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .text_byte  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // end of text always leads to work, so intake closes on the next cycle
   `ILP_ASSERT_NEXT(a_eot_closes_intake, clock, reset, req_tvalid && req_tready && req_tuser, !req_tready)

   // kept text bytes are never the final item of a step
   `ILP_ASSERT_IMPL(a_byte_not_last, clock, reset, rsp_tvalid && (rsp_tuser != ROLE_STATUS), !rsp_tlast)

   // the file end status always closes its step
   `ILP_ASSERT_IMPL(a_file_end_last, clock, reset, rsp_tvalid && (rsp_tdata[10:8] == KIND_FILE_END), rsp_tlast && (rsp_tuser == ROLE_STATUS))

endmodule

### rtl/ilp_ram.sv
// ----------------------------------------------------------------------------
// INI line parser RAM
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ilp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ilp_ctrl.sv
// ----------------------------------------------------------------------------
// INI line parser controller
// Sequences byte intake, line analysis passes, emission and status items.
// ----------------------------------------------------------------------------
module ilp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_eot,
   output logic                req_tready,
   input  ilp_pkg::status_type status,
   output ilp_pkg::cmd_type    cmd
);
   import ilp_pkg::*;

   state_type state_ff, state_in;
   logic      eot_pend_ff, eot_pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         eot_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         eot_pend_ff <= eot_pend_in;
      end
   end

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      eot_pend_in = eot_pend_ff;
      req_tready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_eot) begin
                  if (status.has_line) begin
                     cmd.line_begin = 1'b1;
                     eot_pend_in    = 1'b1;
                     state_in       = ST_CLASS;
                  end else begin
                     state_in = ST_FILE_END;
                  end
               end else begin
                  cmd.wr_byte = 1'b1;
                  if (status.ends_line) begin
                     cmd.line_begin = 1'b1;
                     eot_pend_in    = 1'b0;
                     state_in       = ST_CLASS;
                  end
               end
            end
         end
         ST_CLASS: begin
            if (status.stopped) begin
               cmd.set_plan = 1'b1;
               cmd.plan     = PLAN_EMPTY;
               cmd.kind     = KIND_IGNORED;
               state_in     = ST_STATUS;
            end else if (status.blank) begin
               cmd.set_plan = 1'b1;
               cmd.plan     = PLAN_EMPTY;
               cmd.kind     = KIND_BLANK;
               state_in     = ST_STATUS;
            end else if (status.cont) begin
               cmd.set_plan = 1'b1;
               cmd.plan     = PLAN_CONT;
               cmd.kind     = KIND_CONT;
               state_in     = ST_EMIT_CHK;
            end else begin
               cmd.load_scan = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         ST_DECIDE: begin
            if (status.is_sect && status.sect_ok) begin
               cmd.set_plan = 1'b1;
               cmd.plan     = PLAN_SECT;
               cmd.kind     = KIND_SECTION;
               state_in     = ST_EMIT_CHK;
            end else if (!status.is_sect && status.pair_found) begin
               cmd.load_vscan = 1'b1;
               state_in       = ST_VSCAN;
            end else begin
               cmd.set_plan = 1'b1;
               cmd.plan     = PLAN_EMPTY;
               cmd.kind     = KIND_ERROR;
               state_in     = ST_STATUS;
            end
         end
         ST_VSCAN: begin
            if (status.scan_done) begin
               cmd.set_plan = 1'b1;
               cmd.plan     = PLAN_PAIR;
               cmd.kind     = KIND_PAIR;
               state_in     = ST_EMIT_CHK;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         ST_EMIT_CHK: begin
            if (status.cur_valid) begin
               state_in = ST_READ;
            end else if (!status.span_b) begin
               cmd.next_span = 1'b1;
            end else begin
               state_in = ST_STATUS;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_EMIT_CHK;
            end
         end
         ST_STATUS: begin
            if (status.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = 1'b1;
               cmd.out_last   = !eot_pend_ff;
               cmd.line_done  = 1'b1;
               state_in       = eot_pend_ff ? ST_FILE_END : ST_IDLE;
            end
         end
         ST_FILE_END: begin
            if (status.out_free) begin
               cmd.out_load     = 1'b1;
               cmd.out_status   = 1'b1;
               cmd.out_file_end = 1'b1;
               cmd.out_last     = 1'b1;
               cmd.parser_reset = 1'b1;
               eot_pend_in      = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/ilp_datapath.sv
// ----------------------------------------------------------------------------
// INI line parser datapath
// Line store, per-line trackers, scan passes, span cursor and output register.
// ----------------------------------------------------------------------------
module ilp_datapath #(
   parameter int LINE_BYTES    = ilp_pkg::LINE_BYTES_DEF,
   parameter int SECTION_BYTES = ilp_pkg::SECTION_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ilp_pkg::cmd_type                  cmd,
   output ilp_pkg::status_type               status,
   input  logic [7:0]                        text_byte,
   input  logic                              csr_we,
   input  logic [ilp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic                              csr_wdata,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic                              rsp_tlast,
   output logic [ilp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [1:0]                        rsp_tuser
);
   import ilp_pkg::*;

   localparam int POS_W   = $clog2(LINE_BYTES + 1);
   localparam int AW      = $clog2(LINE_BYTES);
   localparam int SEC_CAP = (SECTION_BYTES - 1 < LINE_BYTES) ? SECTION_BYTES - 1 : LINE_BYTES;
   localparam logic [POS_W-1:0] FILL_MAX = POS_W'(LINE_BYTES - 1);
   localparam logic [POS_W-1:0] SEC_KEEP = POS_W'(SEC_CAP);
   localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_TWO  = POS_W'(2);
   localparam logic [POS_W-1:0] POS_BOM  = POS_W'(3);

   // configuration
   logic cfg_bom_ff, cfg_bom_in, cfg_ml_ff, cfg_ml_in, cfg_stop_ff, cfg_stop_in;

   // line trackers
   logic [POS_W-1:0] fill_ff, fill_in, n_ff, n_in, lnw_ff, lnw_in;
   logic [POS_W-1:0] fnw_ff, fnw_in, fnw3_ff, fnw3_in;
   logic             fnw_ok_ff, fnw_ok_in, fnw3_ok_ff, fnw3_ok_in;
   logic [7:0]       fnwc_ff, fnwc_in, fnw3c_ff, fnw3c_in;
   logic             zero_ff, zero_in, bom_ok_ff, bom_ok_in;

   logic [15:0] lc_ff, lc_in, err_ff, err_in;
   logic        pair_open_ff, pair_open_in;

   // scan passes
   logic [POS_W-1:0] ptr_ff, ptr_in, dpos_ff, dpos_in;
   logic             dv_ff, dv_in, vmode_ff, vmode_in, was_ff, was_in, stop_ff, stop_in;
   logic             rb_ok_ff, rb_ok_in, eq_ok_ff, eq_ok_in, col_ok_ff, col_ok_in;
   logic [POS_W-1:0] p_rb_ff, p_rb_in, p_eq_ff, p_eq_in, p_col_ff, p_col_in;
   logic [POS_W-1:0] ne_eq_ff, ne_eq_in, ne_col_ff, ne_col_in, lnw_run_ff, lnw_run_in;
   logic             vs_ok_ff, vs_ok_in;
   logic [POS_W-1:0] vs_ff, vs_in, ve_ff, ve_in;

   // emission
   kind_type         kind_ff, kind_in;
   role_type         a_role_ff, a_role_in;
   logic [POS_W-1:0] a_hi_ff, a_hi_in, b_lo_ff, b_lo_in, b_hi_ff, b_hi_in;
   logic [POS_W-1:0] cur_ff, cur_in;
   logic             phb_ff, phb_in;

   // output register
   logic       rsp_v_ff, rsp_v_in, rsp_last_ff, rsp_last_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   role_type   rsp_role_ff, rsp_role_in;
   kind_type   rsp_kind_ff, rsp_kind_in;
   logic [15:0] rsp_ln_ff, rsp_ln_in, rsp_err_ff, rsp_err_in;

   // combinational
   logic             bom_w, issue_w, ram_re;
   logic [POS_W-1:0] s_w, e_w, p_w, ne_w, sec_len_w, sec_keep_w;
   logic [7:0]       c_w, ram_q;
   logic [AW-1:0]    ram_ra;
   role_type         plan_role_w;
   logic [POS_W-1:0] plan_a_lo_w, plan_a_hi_w, plan_b_lo_w, plan_b_hi_w;

   // ---------------------------------------------------------------- store
   assign issue_w = cmd.scan_run && (ptr_ff < e_w);
   assign ram_re  = issue_w || cmd.rd_issue;
   assign ram_ra  = cmd.rd_issue ? cur_ff[AW-1:0] : ptr_ff[AW-1:0];

   ilp_ram #(
      .WIDTH (8),
      .DEPTH (LINE_BYTES)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (cmd.wr_byte),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (text_byte),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_q)
   );

   // -------------------------------------------------------- line geometry
   assign bom_w = cfg_bom_ff && (lc_ff == 16'd1) && bom_ok_ff && (n_ff >= POS_BOM);
   assign e_w   = lnw_ff;
   assign s_w   = bom_w ? (fnw3_ok_ff ? fnw3_ff : e_w) : (fnw_ok_ff ? fnw_ff : e_w);
   assign c_w   = bom_w ? fnw3c_ff : fnwc_ff;
   assign p_w   = eq_ok_ff ? p_eq_ff : p_col_ff;
   assign ne_w  = eq_ok_ff ? ne_eq_ff : ne_col_ff;

   assign sec_len_w  = p_rb_ff - s_w - POS_ONE;
   assign sec_keep_w = (sec_len_w > SEC_KEEP) ? SEC_KEEP : sec_len_w;

   always_comb begin
      plan_role_w = ROLE_VALUE;
      plan_a_lo_w = '0;
      plan_a_hi_w = '0;
      plan_b_lo_w = '0;
      plan_b_hi_w = '0;
      case (cmd.plan)
         PLAN_CONT: begin
            plan_a_lo_w = s_w;
            plan_a_hi_w = e_w;
         end
         PLAN_SECT: begin
            plan_role_w = ROLE_SECTION;
            plan_a_lo_w = s_w + POS_ONE;
            plan_a_hi_w = s_w + POS_ONE + sec_keep_w;
         end
         PLAN_PAIR: begin
            plan_role_w = ROLE_NAME;
            plan_a_lo_w = s_w;
            plan_a_hi_w = ne_w;
            plan_b_lo_w = vs_ff;
            plan_b_hi_w = ve_ff;
         end
         default: begin
         end
      endcase
   end

   // --------------------------------------------------------------- status
   always_comb begin
      status            = '0;
      status.ends_line  = (text_byte == CH_NL) || ((fill_ff + POS_ONE) >= FILL_MAX);
      status.has_line   = (fill_ff != '0);
      status.stopped    = cfg_stop_ff && (err_ff != 16'd0);
      status.blank      = (s_w >= e_w) || (c_w == CH_SEMI) || (c_w == CH_HASH);
      status.cont       = cfg_ml_ff && pair_open_ff && (s_w != '0);
      status.is_sect    = (c_w == CH_LBR);
      status.scan_done  = (ptr_ff >= e_w) && !dv_ff;
      status.sect_ok    = rb_ok_ff;
      status.pair_found = eq_ok_ff || col_ok_ff;
      status.cur_valid  = phb_ff ? (cur_ff < b_hi_ff) : (cur_ff < a_hi_ff);
      status.span_b     = phb_ff;
      status.out_free   = !rsp_v_ff || rsp_tready;
   end

   // --------------------------------------------------------- next values
   always_comb begin
      cfg_bom_in  = cfg_bom_ff;
      cfg_ml_in   = cfg_ml_ff;
      cfg_stop_in = cfg_stop_ff;
      if (csr_we) begin
         case (csr_type'(csr_addr))
            CSR_ALLOW_BOM:       cfg_bom_in  = csr_wdata;
            CSR_ALLOW_MULTILINE: cfg_ml_in   = csr_wdata;
            CSR_STOP_ON_ERROR:   cfg_stop_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      fill_in    = fill_ff;
      n_in       = n_ff;
      lnw_in     = lnw_ff;
      fnw_in     = fnw_ff;
      fnw_ok_in  = fnw_ok_ff;
      fnwc_in    = fnwc_ff;
      fnw3_in    = fnw3_ff;
      fnw3_ok_in = fnw3_ok_ff;
      fnw3c_in   = fnw3c_ff;
      zero_in    = zero_ff;
      bom_ok_in  = bom_ok_ff;
      if (cmd.parser_reset || cmd.line_done) begin
         fill_in    = '0;
         n_in       = '0;
         lnw_in     = '0;
         fnw_ok_in  = 1'b0;
         fnw3_ok_in = 1'b0;
         zero_in    = 1'b0;
         bom_ok_in  = 1'b0;
      end else if (cmd.wr_byte) begin
         fill_in = fill_ff + POS_ONE;
         // content ends at the first zero byte
         if (!zero_ff) begin
            if (text_byte == CH_NUL) begin
               zero_in = 1'b1;
            end else begin
               n_in = fill_ff + POS_ONE;
               if (!is_ws(text_byte)) begin
                  lnw_in = fill_ff + POS_ONE;
                  if (!fnw_ok_ff) begin
                     fnw_ok_in = 1'b1;
                     fnw_in    = fill_ff;
                     fnwc_in   = text_byte;
                  end
                  if (!fnw3_ok_ff && (fill_ff >= POS_BOM)) begin
                     fnw3_ok_in = 1'b1;
                     fnw3_in    = fill_ff;
                     fnw3c_in   = text_byte;
                  end
               end
            end
         end
         if (fill_ff == '0) begin
            bom_ok_in = (text_byte == BOM_0);
         end else if (fill_ff == POS_ONE) begin
            bom_ok_in = bom_ok_ff && (text_byte == BOM_1);
         end else if (fill_ff == POS_TWO) begin
            bom_ok_in = bom_ok_ff && (text_byte == BOM_2);
         end
      end
   end

   always_comb begin
      lc_in        = lc_ff;
      err_in       = err_ff;
      pair_open_in = pair_open_ff;
      if (cmd.parser_reset) begin
         lc_in        = '0;
         err_in       = '0;
         pair_open_in = 1'b0;
      end else begin
         if (cmd.line_begin && (lc_ff != 16'hFFFF)) begin
            lc_in = lc_ff + 16'd1;
         end
         if (cmd.set_plan) begin
            if ((cmd.kind == KIND_ERROR) && (err_ff == 16'd0)) begin
               err_in = lc_ff;
            end
            if (cmd.plan == PLAN_SECT) begin
               pair_open_in = 1'b0;
            end else if (cmd.plan == PLAN_PAIR) begin
               pair_open_in = (ne_w > s_w);
            end
         end
      end
   end

   always_comb begin
      ptr_in     = ptr_ff;
      dpos_in    = dpos_ff;
      dv_in      = dv_ff;
      vmode_in   = vmode_ff;
      was_in     = was_ff;
      stop_in    = stop_ff;
      rb_ok_in   = rb_ok_ff;
      eq_ok_in   = eq_ok_ff;
      col_ok_in  = col_ok_ff;
      p_rb_in    = p_rb_ff;
      p_eq_in    = p_eq_ff;
      p_col_in   = p_col_ff;
      ne_eq_in   = ne_eq_ff;
      ne_col_in  = ne_col_ff;
      lnw_run_in = lnw_run_ff;
      vs_ok_in   = vs_ok_ff;
      vs_in      = vs_ff;
      ve_in      = ve_ff;
      if (cmd.load_scan) begin
         ptr_in     = s_w;
         dv_in      = 1'b0;
         vmode_in   = 1'b0;
         was_in     = 1'b0;
         stop_in    = 1'b0;
         rb_ok_in   = 1'b0;
         eq_ok_in   = 1'b0;
         col_ok_in  = 1'b0;
         lnw_run_in = s_w;
      end else if (cmd.load_vscan) begin
         ptr_in   = p_w + POS_ONE;
         dv_in    = 1'b0;
         vmode_in = 1'b1;
         was_in   = 1'b0;
         stop_in  = 1'b0;
         vs_ok_in = 1'b0;
         vs_in    = e_w;
         ve_in    = e_w;
      end else if (cmd.scan_run) begin
         dv_in   = issue_w;
         dpos_in = ptr_ff;
         if (issue_w) begin
            ptr_in = ptr_ff + POS_ONE;
         end
         if (dv_ff && !stop_ff) begin
            if (vmode_ff) begin
               // value: skip leading blanks, stop at an inline comment
               if (!vs_ok_ff) begin
                  if (!is_ws(ram_q)) begin
                     vs_ok_in = 1'b1;
                     vs_in    = dpos_ff;
                     ve_in    = dpos_ff + POS_ONE;
                     was_in   = 1'b0;
                  end
               end else if (was_ff && (ram_q == CH_SEMI)) begin
                  stop_in = 1'b1;
               end else begin
                  was_in = is_ws(ram_q);
                  if (!is_ws(ram_q)) begin
                     ve_in = dpos_ff + POS_ONE;
                  end
               end
            end else if (was_ff && (ram_q == CH_SEMI)) begin
               stop_in = 1'b1;
            end else begin
               if ((ram_q == CH_RBR) && !rb_ok_ff) begin
                  rb_ok_in = 1'b1;
                  p_rb_in  = dpos_ff;
               end
               if ((ram_q == CH_EQ) && !eq_ok_ff) begin
                  eq_ok_in = 1'b1;
                  p_eq_in  = dpos_ff;
                  ne_eq_in = lnw_run_ff;
               end
               if ((ram_q == CH_COLON) && !col_ok_ff) begin
                  col_ok_in = 1'b1;
                  p_col_in  = dpos_ff;
                  ne_col_in = lnw_run_ff;
               end
               was_in = is_ws(ram_q);
               if (!is_ws(ram_q)) begin
                  lnw_run_in = dpos_ff + POS_ONE;
               end
            end
         end
      end
   end

   always_comb begin
      kind_in   = kind_ff;
      a_role_in = a_role_ff;
      a_hi_in   = a_hi_ff;
      b_lo_in   = b_lo_ff;
      b_hi_in   = b_hi_ff;
      cur_in    = cur_ff;
      phb_in    = phb_ff;
      if (cmd.set_plan) begin
         kind_in   = cmd.kind;
         a_role_in = plan_role_w;
         a_hi_in   = plan_a_hi_w;
         b_lo_in   = plan_b_lo_w;
         b_hi_in   = plan_b_hi_w;
         cur_in    = plan_a_lo_w;
         phb_in    = 1'b0;
      end else if (cmd.next_span) begin
         phb_in = 1'b1;
         cur_in = b_lo_ff;
      end else if (cmd.out_load && !cmd.out_status) begin
         cur_in = cur_ff + POS_ONE;
      end
   end

   always_comb begin
      rsp_v_in    = rsp_tready ? 1'b0 : rsp_v_ff;
      rsp_last_in = rsp_last_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_role_in = rsp_role_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_ln_in   = rsp_ln_ff;
      rsp_err_in  = rsp_err_ff;
      if (cmd.out_load) begin
         rsp_v_in    = 1'b1;
         rsp_last_in = cmd.out_last;
         rsp_byte_in = cmd.out_status ? 8'd0 : ram_q;
         rsp_role_in = cmd.out_status ? ROLE_STATUS : (phb_ff ? ROLE_VALUE : a_role_ff);
         rsp_kind_in = cmd.out_file_end ? KIND_FILE_END : kind_ff;
         rsp_ln_in   = lc_ff;
         rsp_err_in  = err_ff;
      end
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_bom_ff   <= 1'b1;
         cfg_ml_ff    <= 1'b1;
         cfg_stop_ff  <= 1'b0;
         fill_ff      <= '0;
         n_ff         <= '0;
         lnw_ff       <= '0;
         fnw_ok_ff    <= 1'b0;
         fnw3_ok_ff   <= 1'b0;
         zero_ff      <= 1'b0;
         bom_ok_ff    <= 1'b0;
         lc_ff        <= '0;
         err_ff       <= '0;
         pair_open_ff <= 1'b0;
         ptr_ff       <= '0;
         dv_ff        <= 1'b0;
         stop_ff      <= 1'b0;
         a_hi_ff      <= '0;
         b_hi_ff      <= '0;
         cur_ff       <= '0;
         phb_ff       <= 1'b0;
         rsp_v_ff     <= 1'b0;
      end else begin
         cfg_bom_ff   <= cfg_bom_in;
         cfg_ml_ff    <= cfg_ml_in;
         cfg_stop_ff  <= cfg_stop_in;
         fill_ff      <= fill_in;
         n_ff         <= n_in;
         lnw_ff       <= lnw_in;
         fnw_ok_ff    <= fnw_ok_in;
         fnw3_ok_ff   <= fnw3_ok_in;
         zero_ff      <= zero_in;
         bom_ok_ff    <= bom_ok_in;
         lc_ff        <= lc_in;
         err_ff       <= err_in;
         pair_open_ff <= pair_open_in;
         ptr_ff       <= ptr_in;
         dv_ff        <= dv_in;
         stop_ff      <= stop_in;
         a_hi_ff      <= a_hi_in;
         b_hi_ff      <= b_hi_in;
         cur_ff       <= cur_in;
         phb_ff       <= phb_in;
         rsp_v_ff     <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      fnw_ff      <= fnw_in;
      fnwc_ff     <= fnwc_in;
      fnw3_ff     <= fnw3_in;
      fnw3c_ff    <= fnw3c_in;
      dpos_ff     <= dpos_in;
      vmode_ff    <= vmode_in;
      was_ff      <= was_in;
      rb_ok_ff    <= rb_ok_in;
      eq_ok_ff    <= eq_ok_in;
      col_ok_ff   <= col_ok_in;
      p_rb_ff     <= p_rb_in;
      p_eq_ff     <= p_eq_in;
      p_col_ff    <= p_col_in;
      ne_eq_ff    <= ne_eq_in;
      ne_col_ff   <= ne_col_in;
      lnw_run_ff  <= lnw_run_in;
      vs_ok_ff    <= vs_ok_in;
      vs_ff       <= vs_in;
      ve_ff       <= ve_in;
      kind_ff     <= kind_in;
      a_role_ff   <= a_role_in;
      b_lo_ff     <= b_lo_in;
      rsp_last_ff <= rsp_last_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_role_ff <= rsp_role_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ln_ff   <= rsp_ln_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_role_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_err_ff, rsp_ln_ff, rsp_kind_ff, rsp_byte_ff};

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// INI line parser testbench
// Streams INI text bytes into the parser and checks every byte and status
// item against a built-in line classifier, with random bursts and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import ilp_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int NUM_ITEMS   = 340;      // minimum input items over the whole run
   localparam int MAX_LINE    = 63;       // bytes held before a line splits
   localparam int SECT_KEEP   = 49;       // section name bytes kept
   localparam int SETTLE      = 400;      // idle wait after the last result

   typedef struct {
      logic [7:0]  text;
      role_type    role;
      kind_type    kind;
      logic [15:0] line_no;
      logic [15:0] err_line;
      logic        last;
   } parsed_item_t;

   // directed row: text with markers; '@' = zero byte, '^' = byte order mark,
   // '%' = 0xFF, '!' = end of text. want < 0 means classifier only.
   typedef struct {
      string text;
      int    want;
   } text_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;    // text_byte
   logic                  req_tuser = 1'b0;  // end_of_text
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // out_byte[7:0], line_kind[10:8], line_number[26:11], first_error_line[42:27]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;         // role
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic                  csr_wdata = 1'b0;

   ini_text_line_parser uut (.*);

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------------
   // Line classifier: own copy of the parser state and registers
   // ---------------------------------------------------------------------
   logic [7:0]   line_buf [64];
   int           line_fill;
   logic [15:0]  line_cnt, err_line;
   bit           pair_open;
   bit           cfg_bom = 1, cfg_multi = 1, cfg_stop = 0;
   parsed_item_t parsed_q [$];
   int           pushed_n;
   kind_type     last_kind;

   int fails, items_sent, items_seen, lines_seen, eot_seen;
   int kind_hits [7];
   bit hold_req;
   int burst_left;

   function automatic bit ws(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   // first position holding target, or a ';' that follows whitespace
   function automatic int find_delim(int from, int to, logic [7:0] target);
      bit was_ws = 0;
      int p = from;
      while (p < to && line_buf[p] != target && !(was_ws && line_buf[p] == CH_SEMI)) begin
         was_ws = ws(line_buf[p]);
         p++;
      end
      return p;
   endfunction

   function automatic void push_item(logic [7:0] b, role_type r, kind_type k);
      parsed_item_t it;
      it.text = b; it.role = r; it.kind = k;
      it.line_no = line_cnt; it.err_line = err_line; it.last = 0;
      parsed_q.push_back(it);
      pushed_n++;
      last_kind = k;
   endfunction

   function automatic void push_span(int a, int b, role_type r, kind_type k);
      for (int i = a; i < b; i++) push_item(line_buf[i], r, k);
   endfunction

   function automatic void close_line();
      int n = 0, s = 0, e, p, ne, vs, ve, len;
      kind_type k = KIND_BLANK;
      while (n < line_fill && line_buf[n] != CH_NUL) n++;
      if (line_cnt != 16'hFFFF) line_cnt++;
      if (cfg_stop && err_line != 0) begin
         k = KIND_IGNORED;
      end else begin
         if (cfg_bom && line_cnt == 1 && n >= 3 && line_buf[0] == BOM_0 &&
             line_buf[1] == BOM_1 && line_buf[2] == BOM_2) s = 3;
         e = n;
         while (e > s && ws(line_buf[e-1])) e--;
         while (s < e && ws(line_buf[s])) s++;
         if (s >= e || line_buf[s] == CH_SEMI || line_buf[s] == CH_HASH) begin
            k = KIND_BLANK;
         end else if (cfg_multi && pair_open && s > 0) begin
            k = KIND_CONT;
            push_span(s, e, ROLE_VALUE, k);
         end else if (line_buf[s] == CH_LBR) begin
            p = find_delim(s + 1, e, CH_RBR);
            if (p < e && line_buf[p] == CH_RBR) begin
               len = p - s - 1;
               if (len > SECT_KEEP) len = SECT_KEEP;
               k = KIND_SECTION;
               push_span(s + 1, s + 1 + len, ROLE_SECTION, k);
               pair_open = 0;
            end else begin
               k = KIND_ERROR;
            end
         end else begin
            p = find_delim(s, e, CH_EQ);
            if (!(p < e && line_buf[p] == CH_EQ)) p = find_delim(s, e, CH_COLON);
            if (p < e && (line_buf[p] == CH_EQ || line_buf[p] == CH_COLON)) begin
               ne = p; vs = p + 1;
               while (ne > s && ws(line_buf[ne-1])) ne--;
               while (vs < e && ws(line_buf[vs])) vs++;
               ve = find_delim(vs, e, CH_NUL);
               while (ve > vs && ws(line_buf[ve-1])) ve--;
               k = KIND_PAIR;
               push_span(s, ne, ROLE_NAME, k);
               push_span(vs, ve, ROLE_VALUE, k);
               pair_open = ne > s;
            end else begin
               k = KIND_ERROR;
            end
         end
         if (k == KIND_ERROR && err_line == 0) err_line = line_cnt;
      end
      line_fill = 0;
      push_item(8'h00, ROLE_STATUS, k);
   endfunction

   function automatic void parse_item(logic [7:0] b, logic eot);
      int before_n = parsed_q.size();
      if (eot) begin
         if (line_fill > 0) close_line();
         push_item(8'h00, ROLE_STATUS, KIND_FILE_END);
         line_fill = 0; line_cnt = 0; err_line = 0; pair_open = 0;
      end else begin
         if (line_fill < MAX_LINE) line_buf[line_fill++] = b;
         if (b == CH_NL || line_fill >= MAX_LINE) close_line();
      end
      if (parsed_q.size() > before_n) parsed_q[parsed_q.size()-1].last = 1;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: bursts of random length, random gaps; drives at falling edge
   // ---------------------------------------------------------------------
   task automatic send_item(logic [7:0] b, logic eot);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= eot ? 8'($urandom) : b;  // byte is don't-care on end of text
      req_tuser  <= eot;
      do @(posedge clock); while (!req_tready);
      parse_item(b, eot);
      items_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      foreach (s[i]) begin
         case (s[i])
            "@":     send_item(8'h00, 1'b0);
            "%":     send_item(8'hFF, 1'b0);
            "!":     send_item(8'h00, 1'b1);
            "^": begin
               send_item(BOM_0, 1'b0); send_item(BOM_1, 1'b0); send_item(BOM_2, 1'b0);
            end
            default: send_item(s[i], 1'b0);
         endcase
      end
   endtask

   // registers only change while nothing is in flight
   task automatic write_regs(bit bom, bit multi, bit stop);
      req_tvalid <= 1'b0;
      burst_left = 0;
      wait (parsed_q.size() == 0);
      repeat (20) @(negedge clock);
      csr_we <= 1'b1; csr_addr <= CSR_ALLOW_BOM;       csr_wdata <= bom;
      @(negedge clock);
      csr_addr <= CSR_ALLOW_MULTILINE; csr_wdata <= multi;
      @(negedge clock);
      csr_addr <= CSR_STOP_ON_ERROR;   csr_wdata <= stop;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_bom = bom; cfg_multi = multi; cfg_stop = stop;
   endtask

   function automatic string word(int len);
      string w = "";
      for (int i = 0; i < len; i++) w = {w, string'(8'($urandom_range(97, 122)))};
      return w;
   endfunction

   function automatic string pad();
      case ($urandom_range(0, 3))
         0:       return "";
         1:       return " ";
         2:       return "\t";
         default: return "  ";
      endcase
   endfunction

   // mostly well-formed lines with random content, some noise
   task automatic send_random_line();
      string s;
      int n;
      case ($urandom_range(0, 11))
         0, 1, 2: begin
            s = {pad(), word($urandom_range(0, 6)), pad(),
                 ($urandom_range(0, 1) ? "=" : ":"), pad(), word($urandom_range(0, 8))};
            case ($urandom_range(0, 3))
               0: s = {s, " ; ", word(3)};
               1: s = {s, ";", word(2)};
               default: s = {s, pad()};
            endcase
            send_text({s, ($urandom_range(0, 4) == 0) ? "\r\n" : "\n"});
         end
         3, 4: send_text({pad(), "[", pad(), word($urandom_range(0, 8)),
                          ($urandom_range(0, 4) == 0) ? "" : "]", pad(), "\n"});
         5, 6: send_text({" ", pad(), word($urandom_range(1, 10)), "\n"});
         7: send_text({pad(), ($urandom_range(0, 1) ? ";" : "#"), word(4), "\n"});
         8: begin
            n = $urandom_range(1, 70);
            repeat (n) send_item(8'($urandom), 1'b0);
         end
         9: begin
            n = $urandom_range(60, 130);
            repeat (n) send_item(8'($urandom_range(32, 126)), 1'b0);
            send_item(CH_NL, 1'b0);
         end
         10: send_text({"^", pad(), word(3), "=", word(3), "\n"});
         default: send_text({"!"});
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Receiver: own stall pattern, plus one long hold-off
   // ---------------------------------------------------------------------
   int rx_cycle, hold_left;
   bit hold_done;
   always @(negedge clock) begin
      rx_cycle++;
      if (hold_req && !hold_done) begin
         hold_done = 1;
         hold_left = 600;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case ((rx_cycle / 80) % 3)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 1) == 1);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: compare each item with the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      parsed_item_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         items_seen++;
         if (parsed_q.size() == 0) begin
            $display("%0t: unexpected item tdata=%h role=%0d last=%0b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            fails++;
         end else begin
            want = parsed_q.pop_front();
            if (want.role == ROLE_STATUS) begin
               lines_seen++;
               kind_hits[want.kind]++;
            end
            if (rsp_tdata[7:0] !== want.text || rsp_tuser !== want.role ||
                rsp_tdata[10:8] !== want.kind || rsp_tdata[26:11] !== want.line_no ||
                rsp_tdata[42:27] !== want.err_line || rsp_tlast !== want.last) begin
               $display("%0t: mismatch expected byte=%h role=%0d kind=%0d line=%0d err=%0d last=%0b",
                        $time, want.text, want.role, want.kind, want.line_no,
                        want.err_line, want.last);
               $display("%0t:          actual byte=%h role=%0d kind=%0d line=%0d err=%0d last=%0b",
                        $time, rsp_tdata[7:0], rsp_tuser, rsp_tdata[10:8],
                        rsp_tdata[26:11], rsp_tdata[42:27], rsp_tlast);
               fails++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   text_row_t rows [$];

   initial begin
      string long_sect, long_line;
      int start_n;
      long_sect = "[";
      repeat (55) long_sect = {long_sect, "s"};
      long_line = "";
      repeat (70) long_line = {long_line, "v"};

      // after reset: byte order mark allowed, multiline on, stop off
      rows = '{
         '{"^name = value\n", KIND_PAIR},
         '{"  more text\n", KIND_CONT},
         '{"[core]\n", KIND_SECTION},
         '{"key:val ; note\n", KIND_PAIR},
         '{"a=b;c\n", KIND_PAIR},
         '{"; only comment\n", KIND_BLANK},
         '{"# hash\n", KIND_BLANK},
         '{" \t \r\n", KIND_BLANK},
         '{"=orphan\n", KIND_PAIR},
         '{"  indented\n", KIND_ERROR},    // empty name leaves no pair open
         '{"[open\n", KIND_ERROR},
         '{"x=1@junk\n", KIND_PAIR},       // zero byte cuts the line
         '{"%\n", KIND_ERROR},
         '{{long_sect, "]\n"}, KIND_SECTION},
         '{{long_line, "\n"}, -1},         // splits at the buffer limit
         '{"tail", -1},
         '{"!", KIND_FILE_END}
      };

      reset <= 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         start_n = pushed_n;
         send_text(rows[i].text);
         if (rows[i].want >= 0 && (pushed_n == start_n ||
             last_kind != kind_type'(rows[i].want))) begin
            $display("%0t: directed row %0d expected kind %0d, actual kind %0d",
                     $time, i, rows[i].want, last_kind);
            fails++;
         end
      end

      // other extremes: mark not skipped, no multiline, stop after an error
      write_regs(0, 0, 1);
      send_text("^a=b\n  cont\nbad\nc=d\n[s]\n!");

      // random phases, each under its own register setting
      for (int ph = 0; ph < 2 || items_sent < NUM_ITEMS; ph++) begin
         case (ph % 5)
            0: write_regs(1, 1, 0);
            1: write_regs(1, 1, 1);
            2: write_regs(0, 1, 0);
            3: write_regs(1, 0, 1);
            default: write_regs($urandom_range(0, 1), $urandom_range(0, 1),
                                $urandom_range(0, 1));
         endcase
         if (ph == 1) hold_req = 1;
         for (int n = 0; n < 20; ) begin
            start_n = items_sent;
            send_random_line();
            n += items_sent - start_n;
         end
         send_text("!");
      end
      req_tvalid <= 1'b0;

      wait (parsed_q.size() == 0);
      repeat (SETTLE) @(posedge clock);

      $display("sent %0d items, checked %0d results over %0d lines", items_sent,
               items_seen, lines_seen);
      $display("kinds blank/sect/pair/cont/err/ign/end: %0d %0d %0d %0d %0d %0d %0d",
               kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3],
               kind_hits[4], kind_hits[5], kind_hits[6]);
      if (fails == 0 && parsed_q.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(5_000_000);
      $display("timeout with %0d results outstanding", parsed_q.size());
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/ilp_pkg.sv
rtl/ilp_ram.sv
rtl/ilp_ctrl.sv
rtl/ilp_datapath.sv
rtl/ini_text_line_parser.sv
dv/tb_top.sv
